>>> src/wmmcd_pkg.sv
// shared types, constants and the lane table of the min/max column decimator
`timescale 1ns / 1ps
`default_nettype none
package wmmcd_pkg;

    localparam int LANE_SPAN   = 200;
    localparam int GAIN_MARGIN = 10;

    localparam int NC_W      = 3;
    localparam int FPC_W     = 16;
    localparam int CFG_W     = 16;
    localparam int COLUMN_W  = 10;
    localparam int CHANNEL_W = 3;
    localparam int ROW_W     = 9;
    localparam int LANE_W    = 8;
    localparam int CENTRE_W  = 10;
    localparam int OUT_W     = 32;

    typedef enum logic [0:0] {
        CFG_NUM_CHANNELS      = 1'b0,
        CFG_FRAMES_PER_COLUMN = 1'b1
    } t_cfg_index;

    // what the row mapper needs besides the two peaks
    typedef struct packed {
        logic [COLUMN_W-1:0]  column;
        logic [CHANNEL_W-1:0] channel;
        logic [CENTRE_W-1:0]  centre;
        logic [LANE_W-1:0]    gain;
    } t_bar_req;

    // one finished peak bar, column in the lowest bits
    typedef struct packed {
        logic [ROW_W-1:0]     bottom_row;
        logic [ROW_W-1:0]     top_row;
        logic [CHANNEL_W-1:0] channel;
        logic [COLUMN_W-1:0]  column;
    } t_bar;

    // lane height in rows for a given channel count (count already clamped to 1..8)
    function automatic logic [LANE_W-1:0] lane_height(input logic [NC_W:0] n);
        logic [LANE_W-1:0] h;
        case (n)
            4'd1:    h = LANE_W'(LANE_SPAN / 1);
            4'd2:    h = LANE_W'(LANE_SPAN / 2);
            4'd3:    h = LANE_W'(LANE_SPAN / 3);
            4'd4:    h = LANE_W'(LANE_SPAN / 4);
            4'd5:    h = LANE_W'(LANE_SPAN / 5);
            4'd6:    h = LANE_W'(LANE_SPAN / 6);
            4'd7:    h = LANE_W'(LANE_SPAN / 7);
            4'd8:    h = LANE_W'(LANE_SPAN / 8);
            default: h = LANE_W'(LANE_SPAN / 1);
        endcase
        return h;
    endfunction

endpackage
`default_nettype wire

>>> src/wmmcd_row_map.sv
// two-stage mapping of a bin's peaks onto the top and bottom pixel rows
`timescale 1ns / 1ps
`default_nettype none
module wmmcd_row_map #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  wmmcd_pkg::t_bar_req        i_req,
    input  logic signed [SAMPLE_BITS-1:0] i_max,
    input  logic signed [SAMPLE_BITS-1:0] i_min,
    output logic                       o_valid,
    output wmmcd_pkg::t_bar            o_bar
);
    import wmmcd_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + LANE_W + 1;
    localparam int SH_W   = PROD_W - (SAMPLE_BITS - 1);

    logic                     r_p_valid;
    t_bar_req                 r_p_req;
    logic signed [PROD_W-1:0] r_p_max;
    logic signed [PROD_W-1:0] r_p_min;

    logic signed [SH_W-1:0]   sh_max;
    logic signed [SH_W-1:0]   sh_min;
    logic signed [CENTRE_W:0] row_top;
    logic signed [CENTRE_W:0] row_bot;
    logic signed [CENTRE_W:0] row_bot_adj;
    logic signed [LANE_W:0]   gain_s;

    t_bar r_bar;
    t_bar n_bar;
    logic r_valid;

    assign gain_s = $signed({1'b0, i_req.gain});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= i_valid;
        end
        r_p_req <= i_req;
        r_p_max <= PROD_W'(i_max) * PROD_W'(gain_s);
        r_p_min <= PROD_W'(i_min) * PROD_W'(gain_s);
    end

    // floor of the product over 2^(SAMPLE_BITS-1) is the upper slice
    always_comb begin
        sh_max      = r_p_max[PROD_W-1:SAMPLE_BITS-1];
        sh_min      = r_p_min[PROD_W-1:SAMPLE_BITS-1];
        row_top     = $signed({1'b0, r_p_req.centre}) - (CENTRE_W + 1)'(sh_max);
        row_bot     = $signed({1'b0, r_p_req.centre}) - (CENTRE_W + 1)'(sh_min);
        row_bot_adj = (row_top == row_bot) ? row_bot - (CENTRE_W + 1)'(1) : row_bot;
        n_bar.column     = r_p_req.column;
        n_bar.channel    = r_p_req.channel;
        n_bar.top_row    = row_top[ROW_W-1:0];
        n_bar.bottom_row = row_bot_adj[ROW_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_p_valid;
        end
        r_bar <= n_bar;
    end

    assign o_valid = r_valid;
    assign o_bar   = r_bar;

    a_rows_differ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_bar.top_row != o_bar.bottom_row)
        else $error("peak bar has equal top and bottom rows");

endmodule
`default_nettype wire

>>> src/waveform_min_max_column_decimator.sv
// top level: sample counters, per-channel peak memory, row mapping and result queue
//
//  channel  dir  handshake                       payload
//  s_axis   in   i_s_axis_tvalid/o_s_axis_tready tdata: sample; tuser: restart
//  m_axis   out  o_m_axis_tvalid/i_m_axis_tready tdata: column, channel, top, bottom row
//  cfg      in   i_cfg_we                        i_cfg_index, i_cfg_wdata
//
// one sample a cycle while the input is ready; a result passes through peak memory
// read, read-modify-write and two row-mapping stages, then waits in an 8-deep queue.
// synchronous reset clears counters, valid flags and the queue; no clearing pass.
// the input stalls only when the queue plus results in flight reach 8 beats.
`timescale 1ns / 1ps
`default_nettype none
module waveform_min_max_column_decimator #(
    parameter int COLUMNS      = 960,
    parameter int MAX_CHANNELS = 6,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample [SAMPLE_BITS-1:0], zero padding above
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] i_s_axis_tdata,
    // restart [0]
    input  logic                                i_s_axis_tuser,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // column [9:0], channel [12:10], top_row [21:13], bottom_row [30:22], zero [31]
    output logic [wmmcd_pkg::OUT_W-1:0]         o_m_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic                                i_cfg_we,
    input  wmmcd_pkg::t_cfg_index               i_cfg_index,
    input  logic [wmmcd_pkg::CFG_W-1:0]         i_cfg_wdata
);
    import wmmcd_pkg::*;

    localparam int COL_W    = $clog2(COLUMNS + 1);
    localparam int CH_AW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PK_W     = 2 * SAMPLE_BITS;
    localparam int Q_DEPTH  = 8;
    localparam int Q_AW     = 3;

    // configuration
    logic [NC_W-1:0]  r_num_channels;
    logic [FPC_W-1:0] r_frames;
    logic [NC_W:0]    nc_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_channels <= NC_W'(1);
            r_frames       <= FPC_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NUM_CHANNELS:      r_num_channels <= i_cfg_wdata[NC_W-1:0];
                CFG_FRAMES_PER_COLUMN: r_frames       <= i_cfg_wdata[FPC_W-1:0];
                default:               r_num_channels <= r_num_channels;
            endcase
        end
    end

    always_comb begin
        if (r_num_channels == '0) begin
            nc_eff = (NC_W + 1)'(1);
        end else if ({1'b0, r_num_channels} > (NC_W + 1)'(MAX_CHANNELS)) begin
            nc_eff = (NC_W + 1)'(MAX_CHANNELS);
        end else begin
            nc_eff = {1'b0, r_num_channels};
        end
    end

    // position counters
    logic [CHANNEL_W-1:0] r_ch_pos, n_ch_pos;
    logic [FPC_W-1:0]     r_frame, n_frame;
    logic [COL_W-1:0]     r_col, n_col;
    logic [Q_AW:0]        r_used;

    logic                 accept, restart, ignore, take;
    logic [CHANNEL_W-1:0] ch_pos_eff, ch;
    logic [FPC_W-1:0]     frame_eff;
    logic [COL_W-1:0]     col_eff;
    logic                 first, last, chan_end;
    logic signed [SAMPLE_BITS-1:0] sample;

    assign o_s_axis_tready = (r_used != (Q_AW + 1)'(Q_DEPTH));
    assign accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign restart = i_s_axis_tuser;
    assign sample  = $signed(i_s_axis_tdata[SAMPLE_BITS-1:0]);

    always_comb begin
        ch_pos_eff = restart ? '0 : r_ch_pos;
        frame_eff  = restart ? '0 : r_frame;
        col_eff    = restart ? '0 : r_col;
        ignore     = (col_eff >= COL_W'(COLUMNS));
        ch         = ({1'b0, ch_pos_eff} >= nc_eff) ? '0 : ch_pos_eff;
        first      = (frame_eff == '0);
        last       = ({1'b0, frame_eff} + (FPC_W + 1)'(1)) >= {1'b0, r_frames};
        chan_end   = ({1'b0, ch} + (CHANNEL_W + 1)'(1)) >= nc_eff;
        take       = accept && !ignore;
        n_ch_pos   = ch_pos_eff;
        n_frame    = frame_eff;
        n_col      = col_eff;
        if (!ignore) begin
            if (chan_end) begin
                n_ch_pos = '0;
                if (last) begin
                    n_frame = '0;
                    n_col   = col_eff + COL_W'(1);
                end else begin
                    n_frame = frame_eff + FPC_W'(1);
                end
            end else begin
                n_ch_pos = ch + CHANNEL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_pos <= '0;
            r_frame  <= '0;
            r_col    <= '0;
        end else if (accept) begin
            r_ch_pos <= n_ch_pos;
            r_frame  <= n_frame;
            r_col    <= n_col;
        end
    end

    // peak memory: {max, min} per channel, registered read
    logic [PK_W-1:0]         peak_mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] r_ent_vld;
    logic [PK_W-1:0]         r_rd_data;
    logic                    r_rd_vld;

    logic                          r1_valid, r1_first, r1_last;
    logic [CHANNEL_W-1:0]          r1_ch;
    logic [COLUMN_W-1:0]           r1_col;
    logic signed [SAMPLE_BITS-1:0] r1_sample;

    logic                          wr_en;
    logic [CH_AW-1:0]              wr_addr;
    logic signed [SAMPLE_BITS-1:0] old_max, old_min, new_max, new_min;

    logic                          r_fw_valid;
    logic [CH_AW-1:0]              r_fw_addr;
    logic [PK_W-1:0]               r_fw_data;

    assign wr_en   = r1_valid;
    assign wr_addr = r1_ch[CH_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rd_data <= peak_mem[ch[CH_AW-1:0]];
            r_rd_vld  <= r_ent_vld[ch[CH_AW-1:0]];
        end
        if (wr_en) begin
            peak_mem[wr_addr] <= {new_max, new_min};
        end
    end

    // a restart drops every stored peak; it wins over a write in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
        end else if (accept && restart) begin
            r_ent_vld <= '0;
        end else if (wr_en) begin
            r_ent_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= take;
        end
        r1_first  <= first;
        r1_last   <= last;
        r1_ch     <= ch;
        r1_col    <= COLUMN_W'(col_eff);
        r1_sample <= sample;
    end

    // the read issued while the previous beat was writing sees stale data
    always_comb begin
        if (r_fw_valid && (r_fw_addr == r1_ch[CH_AW-1:0])) begin
            old_max = r_fw_data[PK_W-1:SAMPLE_BITS];
            old_min = r_fw_data[SAMPLE_BITS-1:0];
        end else if (r_rd_vld) begin
            old_max = r_rd_data[PK_W-1:SAMPLE_BITS];
            old_min = r_rd_data[SAMPLE_BITS-1:0];
        end else begin
            old_max = '0;
            old_min = '0;
        end
        if (r1_first) begin
            new_max = r1_sample;
            new_min = r1_sample;
        end else begin
            new_max = (r1_sample > old_max) ? r1_sample : old_max;
            new_min = (r1_sample < old_min) ? r1_sample : old_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
        end else begin
            r_fw_valid <= wr_en;
        end
        r_fw_addr <= wr_addr;
        r_fw_data <= {new_max, new_min};
    end

    // lane geometry and the finished bin go to the row mapper
    logic [LANE_W-1:0]   lane;
    logic [11:0]         centre_full;
    t_bar_req            r2_req, n2_req;
    logic                r2_valid;
    logic signed [SAMPLE_BITS-1:0] r2_max, r2_min;

    always_comb begin
        lane           = lane_height(nc_eff);
        centre_full    = 12'(lane) * 12'({r1_ch, 1'b1});
        n2_req.column  = r1_col;
        n2_req.channel = r1_ch;
        n2_req.centre  = centre_full[CENTRE_W-1:0];
        n2_req.gain    = lane - LANE_W'(GAIN_MARGIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid && r1_last;
        end
        r2_req <= n2_req;
        r2_max <= new_max;
        r2_min <= new_min;
    end

    logic row_valid;
    t_bar row_bar;

    wmmcd_row_map #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_row_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_valid),
        .i_req   (r2_req),
        .i_max   (r2_max),
        .i_min   (r2_min),
        .o_valid (row_valid),
        .o_bar   (row_bar)
    );

    // result queue; slots are reserved at accept so the pipeline never stalls
    t_bar            res_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_AW:0]   r_q_cnt;
    logic            pop;

    assign pop = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (row_valid) begin
            res_q[r_wr_ptr] <= row_bar;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_q_cnt  <= '0;
            r_used   <= '0;
        end else begin
            if (row_valid) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            r_q_cnt <= r_q_cnt + (Q_AW + 1)'(row_valid) - (Q_AW + 1)'(pop);
            r_used  <= r_used + (Q_AW + 1)'(take && last) - (Q_AW + 1)'(pop);
        end
    end

    assign o_m_axis_tvalid = (r_q_cnt != '0);
    assign o_m_axis_tdata  = OUT_W'(res_q[r_rd_ptr]);

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= (Q_AW + 1)'(Q_DEPTH))
        else $error("result reservations exceed queue depth");

    a_queue_within_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt <= r_used)
        else $error("queue holds more beats than were reserved");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        row_valid |-> (r_q_cnt != (Q_AW + 1)'(Q_DEPTH)) || pop)
        else $error("result pushed into a full queue");

    a_channel_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ch_pos < CHANNEL_W'(MAX_CHANNELS) || MAX_CHANNELS == 8)
        else $error("channel position beyond channel count");

    a_bar_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_valid |-> $past(r1_valid && r1_last))
        else $error("row mapping started without a finished bin");

endmodule
`default_nettype wire

>>> tb/waveform_min_max_column_decimator_tb.sv
// self-checking min/max column decimator bench: directed plan, past-end run, random phases
`timescale 1ns / 1ps
module waveform_min_max_column_decimator_tb;
    import wmmcd_pkg::*;

    localparam int COLUMNS      = 960;
    localparam int MAX_CH       = 6;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_OFF     = 300;
    localparam int RANDOM_ITEMS = 500;
    localparam int PAST_END_LEN = COLUMNS + 3;

    typedef struct {
        bit          is_cfg;
        logic [15:0] nc_word;
        logic [15:0] fpc_word;
        logic [15:0] smp;
        logic        rst_bin;
        bit          typed;
        t_bar        want;
    } t_plan_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic [15:0]      i_s_axis_tdata = '0;
    logic             i_s_axis_tuser = 1'b0;
    logic             i_s_axis_tvalid = 1'b0;
    logic             o_s_axis_tready;
    logic [OUT_W-1:0] o_m_axis_tdata;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    logic             i_cfg_we = 1'b0;
    t_cfg_index       i_cfg_index = CFG_NUM_CHANNELS;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    // typed expectation travelling alongside the offered beat
    bit   typed_valid = 1'b0;
    t_bar typed_bar = '0;

    // predictor state
    logic [2:0]         cfg_lanes = 3'd1;
    logic [15:0]        cfg_frames = 16'd1;
    logic signed [15:0] lane_hi [MAX_CH];
    logic signed [15:0] lane_lo [MAX_CH];
    int unsigned        slot = 0;
    int unsigned        frame_cnt = 0;
    int unsigned        col_cnt = 0;

    t_bar pending_bars [$];
    int   fail_count = 0;
    int   burst_left = 1;
    bit   hold_off_go = 1'b0;

    waveform_min_max_column_decimator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void clear_bins();
        foreach (lane_hi[k]) begin
            lane_hi[k] = '0;
            lane_lo[k] = '0;
        end
        slot      = 0;
        frame_cnt = 0;
        col_cnt   = 0;
    endfunction

    function automatic bit predict_bar(input logic signed [15:0] smp, input logic rst_bin,
                                       output t_bar bar);
        int unsigned lanes, span, ch;
        longint      height, centre, gain, top, bot;
        bit          last_frame;
        lanes = cfg_lanes;
        if (lanes == 0) lanes = 1;
        if (lanes > MAX_CH) lanes = MAX_CH;
        span = cfg_frames;
        if (span == 0) span = 1;
        bar = '0;
        if (rst_bin) clear_bins();
        if (col_cnt >= COLUMNS) return 1'b0;
        // channel count may have shrunk since the last beat
        if (slot >= lanes) slot = 0;
        ch = slot;
        if (frame_cnt == 0) begin
            lane_hi[ch] = smp;
            lane_lo[ch] = smp;
        end else begin
            if (smp > lane_hi[ch]) lane_hi[ch] = smp;
            if (smp < lane_lo[ch]) lane_lo[ch] = smp;
        end
        last_frame = (frame_cnt + 1 >= span);
        if (last_frame) begin
            height = LANE_SPAN / lanes;
            centre = height * (2 * ch + 1);
            gain   = height - GAIN_MARGIN;
            top    = centre - ((longint'(lane_hi[ch]) * gain) >>> 15);
            bot    = centre - ((longint'(lane_lo[ch]) * gain) >>> 15);
            if (top == bot) bot = bot - 1;
            bar.column     = col_cnt[COLUMN_W-1:0];
            bar.channel    = ch[CHANNEL_W-1:0];
            bar.top_row    = top[ROW_W-1:0];
            bar.bottom_row = bot[ROW_W-1:0];
        end
        if (ch + 1 >= lanes) begin
            slot = 0;
            if (last_frame) begin
                frame_cnt = 0;
                col_cnt++;
            end else begin
                frame_cnt++;
            end
        end else begin
            slot = ch + 1;
        end
        return last_frame;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_bar bar;
        t_bar got;
        t_bar want;
        bit   has_bar;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_NUM_CHANNELS) cfg_lanes = i_cfg_wdata[2:0];
                else cfg_frames = i_cfg_wdata[15:0];
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                has_bar = predict_bar($signed(i_s_axis_tdata), i_s_axis_tuser, bar);
                if (typed_valid) pending_bars.push_back(typed_bar);
                else if (has_bar) pending_bars.push_back(bar);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = t_bar'(o_m_axis_tdata[$bits(t_bar)-1:0]);
                if (pending_bars.size() == 0) begin
                    $error("unexpected result beat %h", o_m_axis_tdata);
                    fail_count++;
                end else begin
                    want = pending_bars.pop_front();
                    if (got.column != want.column) begin
                        $error("column: expected %0d, got %0d", want.column, got.column);
                        fail_count++;
                    end
                    if (got.channel != want.channel) begin
                        $error("channel: expected %0d, got %0d", want.channel, got.channel);
                        fail_count++;
                    end
                    if (got.top_row != want.top_row) begin
                        $error("top_row: expected %0d, got %0d", want.top_row, got.top_row);
                        fail_count++;
                    end
                    if (got.bottom_row != want.bottom_row) begin
                        $error("bottom_row: expected %0d, got %0d",
                               want.bottom_row, got.bottom_row);
                        fail_count++;
                    end
                end
            end
        end
    end

    // result sink: short runs and stalls, plus one long hold-off to back the block up
    initial begin : sink_pacing
        int run_len, stall_len;
        bit held;
        held = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_go && !held) begin
                held = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
            end
            run_len = $urandom_range(1, 30);
            i_m_axis_tready <= 1'b1;
            repeat (run_len) @(posedge i_clk);
            stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (stall_len > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall_len) @(posedge i_clk);
            end
        end
    end

    // the gap after a burst is taken before the next beat is offered
    task automatic offer_sample(input logic [15:0] smp, input logic rst_bin,
                                input bit typed, input t_bar typed_val);
        int gap;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_s_axis_tdata  <= smp;
        i_s_axis_tuser  <= rst_bin;
        i_s_axis_tvalid <= 1'b1;
        typed_valid     <= typed;
        typed_bar       <= typed_val;
        do @(posedge i_clk); while (!o_s_axis_tready);
        burst_left--;
    endtask

    // let every expected bar arrive, then give the pipeline time to empty
    task automatic drain_block();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_bars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic settle_and_configure(input logic [15:0] nc_word, input logic [15:0] fpc_word);
        drain_block();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_NUM_CHANNELS;
        i_cfg_wdata <= nc_word;
        @(posedge i_clk);
        i_cfg_index <= CFG_FRAMES_PER_COLUMN;
        i_cfg_wdata <= fpc_word;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_plan_row cfg_row(input logic [15:0] nc, input logic [15:0] fpc);
        t_plan_row r;
        r = '{is_cfg: 1'b1, nc_word: nc, fpc_word: fpc, smp: '0, rst_bin: 1'b0,
              typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic t_plan_row sample_row(input logic [15:0] smp, input logic rst_bin);
        t_plan_row r;
        r = '{is_cfg: 1'b0, nc_word: '0, fpc_word: '0, smp: smp, rst_bin: rst_bin,
              typed: 1'b0, want: '0};
        return r;
    endfunction

    // single lane, one frame per column: centre 200, gain 190
    function automatic t_plan_row typed_row(input logic [15:0] smp, input logic rst_bin,
                                            input int col, input int top, input int bot);
        t_plan_row r;
        r = sample_row(smp, rst_bin);
        r.typed = 1'b1;
        r.want  = '{bottom_row: ROW_W'(bot), top_row: ROW_W'(top),
                    channel: '0, column: COLUMN_W'(col)};
        return r;
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'($urandom_range(0, 8)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        t_plan_row   plan [$];
        int          rand_items, phase, len;
        logic [15:0] nc_word, fpc_word;
        logic        rst_bin;

        // reset settings: one lane, one frame per column
        plan.push_back(typed_row(16'h7FFF, 1'b0, 0, 11, 10));
        plan.push_back(typed_row(16'h8000, 1'b0, 1, 390, 389));
        plan.push_back(typed_row(16'h0000, 1'b0, 2, 200, 199));
        plan.push_back(typed_row(16'h0001, 1'b1, 0, 200, 199));
        plan.push_back(typed_row(16'hFFFF, 1'b0, 1, 201, 200));
        // widest lane count, two frames per bin
        plan.push_back(cfg_row(16'd6, 16'd2));
        plan.push_back(sample_row(16'h7FFF, 1'b1));
        plan.push_back(sample_row(16'h8000, 1'b0));
        plan.push_back(sample_row(16'h4000, 1'b0));
        plan.push_back(sample_row(16'hC000, 1'b0));
        plan.push_back(sample_row(16'h0001, 1'b0));
        plan.push_back(sample_row(16'hFFFF, 1'b0));
        plan.push_back(sample_row(16'h8000, 1'b0));
        plan.push_back(sample_row(16'h7FFF, 1'b0));
        plan.push_back(sample_row(16'h0000, 1'b0));
        plan.push_back(sample_row(16'h0000, 1'b0));
        plan.push_back(sample_row(16'hFFFE, 1'b0));
        plan.push_back(sample_row(16'h0002, 1'b0));
        // lane count above the maximum and zero frames per column are clamped
        plan.push_back(cfg_row(16'd7, 16'd0));
        plan.push_back(sample_row(16'h8000, 1'b0));
        plan.push_back(sample_row(16'h7FFF, 1'b0));
        plan.push_back(sample_row(16'h0064, 1'b0));
        plan.push_back(sample_row(16'hFF9C, 1'b0));
        // slot left at 4 wraps under a two-lane setting
        plan.push_back(cfg_row(16'd2, 16'd4));
        plan.push_back(sample_row(16'h0005, 1'b0));
        plan.push_back(sample_row(16'hFFFB, 1'b0));
        plan.push_back(sample_row(16'h0007, 1'b0));
        // zero lanes means one; frame count now past the bin length
        plan.push_back(cfg_row(16'd0, 16'd1));
        plan.push_back(sample_row(16'h0009, 1'b0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) settle_and_configure(plan[i].nc_word, plan[i].fpc_word);
            else offer_sample(plan[i].smp, plan[i].rst_bin, plan[i].typed, plan[i].want);
        end

        // run off the last column; the tail beats must be ignored
        settle_and_configure(16'd1, 16'd1);
        for (int k = 0; k < PAST_END_LEN; k++) offer_sample(pick_sample(), k == 0, 1'b0, '0);

        rand_items = 0;
        phase = 0;
        while (rand_items < RANDOM_ITEMS) begin
            nc_word = {13'($urandom), 3'($urandom_range(0, 7))};
            case ($urandom_range(0, 9))
                0:       fpc_word = 16'd0;
                1:       fpc_word = 16'($urandom_range(5, 12));
                default: fpc_word = 16'($urandom_range(1, 4));
            endcase
            if (phase == 0) fpc_word = 16'd1;
            if (phase == 3) fpc_word = 16'hFFFF;
            settle_and_configure(nc_word, fpc_word);
            if (phase == 0) hold_off_go = 1'b1;
            len = (phase == 0) ? 60 : ((phase == 3) ? 20 : $urandom_range(10, 60));
            for (int k = 0; k < len; k++) begin
                rst_bin = (k == 0 && (phase == 0 || $urandom_range(0, 1) == 0))
                          || $urandom_range(0, 49) == 0;
                offer_sample(pick_sample(), rst_bin, 1'b0, '0);
            end
            rand_items += len;
            phase++;
        end

        drain_block();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> waveform_min_max_column_decimator.f
src/wmmcd_pkg.sv
src/wmmcd_row_map.sv
src/waveform_min_max_column_decimator.sv
tb/waveform_min_max_column_decimator_tb.sv
